>>> hw/rtl/ptpm_pkg.sv
// Package for the polynomial text multiplier: parser codes, character codes
// and the command and status records between controller and datapath.
// Depends on nothing.
package ptpm_pkg;

    localparam int DEG_DEFAULT = 32;

    localparam logic [1:0] PH_SIGN    = 2'd0;
    localparam logic [1:0] PH_DIGITS  = 2'd1;
    localparam logic [1:0] PH_AFTER_X = 2'd2;
    localparam logic [1:0] PH_EXP     = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [15:0] EXP_MAX = 16'hFFFF;

    typedef struct packed {
        logic parse;
        logic mac_init;
        logic mac_step;
        logic drain;
        logic next_k;
        logic take_acc;
        logic emit_pend;
        logic emit_final;
        logic clear_stores;
    } ptpm_cmd_t;

    typedef struct packed {
        logic i_last;
        logic k_zero;
        logic acc_nz;
        logic pend_valid;
        logic out_free;
    } ptpm_status_t;

endpackage

>>> hw/rtl/ptpm_in_if.sv
// Input channel of the polynomial text multiplier: one text character a transfer.
// Depends on nothing.
interface ptpm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, kind, text_char, end_of_text, input ready);
    modport sink (input valid, kind, text_char, end_of_text, output ready);
endinterface

>>> hw/rtl/ptpm_out_if.sv
// Output channel of the polynomial text multiplier: one product term a transfer.
// Depends on nothing.
interface ptpm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coefficient;
    logic [5:0]         degree;
    logic               final_term;
    logic               empty_product;

    modport source (output valid, coefficient, degree, final_term, empty_product,
                    input ready);
    modport sink (input valid, coefficient, degree, final_term, empty_product,
                  output ready);
endinterface

>>> hw/rtl/ptpm_ctrl.sv
// Controller of the polynomial text multiplier: sequences parsing, the
// multiply-accumulate walk and emission. Depends on ptpm_pkg.
module ptpm_ctrl
    import ptpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_kind,
    input  logic         in_last,
    output logic         in_ready,
    input  ptpm_status_t status,
    output ptpm_cmd_t    cmd
);

    localparam logic [2:0] ST_PARSE = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_PARSE:
            begin
                in_ready  = 1'b1;
                cmd.parse = in_valid;
                if (in_valid && in_kind && in_last)
                begin
                    cmd.mac_init = 1'b1;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.i_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!(status.acc_nz && status.pend_valid && !status.out_free))
                begin
                    cmd.emit_pend = status.acc_nz && status.pend_valid;
                    cmd.take_acc  = status.acc_nz;
                    if (status.k_zero)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.next_k = 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pend    = 1'b1;
                    cmd.emit_final   = 1'b1;
                    cmd.clear_stores = 1'b1;
                    state_next       = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PARSE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |=> state_reg == ST_MAC || state_reg == ST_DRAIN)
        else $error("multiply walk left early");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |=> state_reg == ST_DONE)
        else $error("drain not followed by the degree check");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= ST_FLUSH)
        else $error("state register holds an unknown code");

endmodule

>>> hw/rtl/ptpm_datapath.sv
// Datapath of the polynomial text multiplier: character parser, both coefficient
// stores, the multiply-accumulate unit and the output register. Depends on ptpm_pkg.
module ptpm_datapath
    import ptpm_pkg::*;
#(
    parameter int DEG = DEG_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptpm_cmd_t          cmd,
    output ptpm_status_t       status,
    input  logic               in_kind,
    input  logic [7:0]         in_text_char,
    input  logic               in_end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_coefficient,
    output logic [5:0]         out_degree,
    output logic               out_final_term,
    output logic               out_empty_product
);

    localparam int IW = $clog2(DEG);
    localparam int KW = $clog2(2 * DEG - 1);

    logic [31:0] a_reg [DEG];
    logic [31:0] b_reg [DEG];

    logic [1:0]  phase_reg;
    logic        sign_reg;
    logic [31:0] dacc_reg;
    logic [15:0] eacc_reg;
    logic        fin_reg;

    logic [1:0]  phase_next;
    logic        sign_next;
    logic [31:0] dacc_next;
    logic [15:0] eacc_next;
    logic        fin_next;

    logic        wa_en;
    logic [IW-1:0] wa_idx;
    logic [31:0] wa_val;
    logic        wb_en;
    logic [IW-1:0] wb_idx;
    logic [31:0] wb_val;

    logic        is_digit;
    logic        is_sign;
    logic [3:0]  digit;
    logic        handled;
    logic [19:0] etmp;
    logic [15:0] eff_exp;

    always_comb
    begin
        phase_next = phase_reg;
        sign_next  = sign_reg;
        dacc_next  = dacc_reg;
        eacc_next  = eacc_reg;
        fin_next   = fin_reg;
        wa_en      = 1'b0;
        wa_idx     = '0;
        wa_val     = '0;
        wb_en      = 1'b0;
        wb_idx     = '0;
        wb_val     = '0;
        handled    = 1'b0;
        is_digit   = in_text_char >= CH_ZERO && in_text_char <= CH_NINE;
        is_sign    = in_text_char == CH_PLUS || in_text_char == CH_MINUS;
        digit      = 4'(in_text_char - CH_ZERO);
        etmp       = '0;
        eff_exp    = '0;
        if (!fin_reg)
        begin
            if (phase_next == PH_SIGN)
            begin
                phase_next = PH_DIGITS;
                if (is_sign)
                begin
                    sign_next = in_text_char == CH_MINUS;
                    handled   = 1'b1;
                end
            end
            if (!handled && phase_next == PH_DIGITS)
            begin
                handled = 1'b1;
                if (is_digit)
                begin
                    dacc_next = (dacc_next << 3) + (dacc_next << 1) + 32'(digit);
                end
                else if (in_text_char == CH_X)
                begin
                    if (dacc_next == '0)
                    begin
                        dacc_next = 32'd1;
                    end
                    phase_next = PH_AFTER_X;
                end
                else
                begin
                    wb_en    = 1'b1;
                    wb_idx   = '0;
                    wb_val   = sign_next ? 32'd0 - dacc_next : dacc_next;
                    fin_next = 1'b1;
                end
            end
            if (!handled && phase_next == PH_AFTER_X)
            begin
                phase_next = PH_EXP;
                handled    = in_text_char == CH_CARET;
            end
            if (!handled && phase_next == PH_EXP)
            begin
                if (is_digit)
                begin
                    etmp = (20'(eacc_next) << 3) + (20'(eacc_next) << 1) + 20'(digit);
                    eacc_next = (etmp > 20'(EXP_MAX)) ? EXP_MAX : etmp[15:0];
                end
                else
                begin
                    eff_exp = (eacc_next == '0) ? 16'd1 : eacc_next;
                    wa_en   = eff_exp < 16'(DEG);
                    wa_idx  = eff_exp[IW-1:0];
                    wa_val  = sign_next ? 32'd0 - dacc_next : dacc_next;
                    sign_next  = 1'b0;
                    dacc_next  = '0;
                    eacc_next  = '0;
                    if (is_sign)
                    begin
                        sign_next  = in_text_char == CH_MINUS;
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        dacc_next  = 32'(digit);
                        phase_next = PH_DIGITS;
                    end
                    else if (in_text_char == CH_X)
                    begin
                        dacc_next  = 32'd1;
                        phase_next = PH_AFTER_X;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        wb_en      = 1'b1;
                        wb_idx     = '0;
                        wb_val     = '0;
                        fin_next   = 1'b1;
                    end
                end
            end
        end
        if (in_end_of_text)
        begin
            if (!fin_next)
            begin
                if (phase_next == PH_DIGITS)
                begin
                    wb_en  = 1'b1;
                    wb_idx = '0;
                    wb_val = sign_next ? 32'd0 - dacc_next : dacc_next;
                end
                else if (phase_next == PH_AFTER_X || phase_next == PH_EXP)
                begin
                    eff_exp = (eacc_next == '0) ? 16'd1 : eacc_next;
                    wb_en   = eff_exp < 16'(DEG);
                    wb_idx  = eff_exp[IW-1:0];
                    wb_val  = sign_next ? 32'd0 - dacc_next : dacc_next;
                end
            end
            phase_next = PH_SIGN;
            sign_next  = 1'b0;
            dacc_next  = '0;
            eacc_next  = '0;
            fin_next   = 1'b0;
        end
        if (wa_en && wb_en && wa_idx == wb_idx)
        begin
            wa_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            sign_reg  <= 1'b0;
            dacc_reg  <= '0;
            eacc_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else if (cmd.parse)
        begin
            phase_reg <= phase_next;
            sign_reg  <= sign_next;
            dacc_reg  <= dacc_next;
            eacc_reg  <= eacc_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < DEG; n++)
            begin
                a_reg[n] <= '0;
                b_reg[n] <= '0;
            end
        end
        else if (cmd.clear_stores)
        begin
            for (int n = 0; n < DEG; n++)
            begin
                a_reg[n] <= '0;
                b_reg[n] <= '0;
            end
        end
        else if (cmd.parse)
        begin
            if (!in_kind)
            begin
                if (wa_en)
                begin
                    a_reg[wa_idx] <= wa_val;
                end
                if (wb_en)
                begin
                    a_reg[wb_idx] <= wb_val;
                end
            end
            else
            begin
                if (wa_en)
                begin
                    b_reg[wa_idx] <= wa_val;
                end
                if (wb_en)
                begin
                    b_reg[wb_idx] <= wb_val;
                end
            end
        end
    end

    logic [IW-1:0] i_reg;
    logic [KW-1:0] k_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   pend_reg;
    logic [KW-1:0] pend_k_reg;
    logic          pend_valid_reg;
    logic [KW:0]   j_diff;
    logic          j_ok;

    assign j_diff = {1'b0, k_reg} - (KW+1)'(i_reg);
    assign j_ok   = !j_diff[KW] && (j_diff < (KW+1)'(DEG));

    always_ff @(posedge clk)
    begin
        if (cmd.mac_init || cmd.next_k)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else if (cmd.mac_step || cmd.drain)
        begin
            prod_reg <= (cmd.mac_step && j_ok) ? a_reg[i_reg] * b_reg[j_diff[IW-1:0]]
                                               : 32'd0;
            acc_reg  <= acc_reg + prod_reg;
        end
        if (cmd.take_acc)
        begin
            pend_reg   <= acc_reg;
            pend_k_reg <= k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mac_init)
            begin
                i_reg          <= '0;
                k_reg          <= KW'(2 * DEG - 2);
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.next_k)
            begin
                i_reg <= '0;
                k_reg <= k_reg - 1'b1;
            end
            else if (cmd.mac_step)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.take_acc)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    logic out_valid_reg;
    logic [31:0] out_coef_reg;
    logic [5:0]  out_deg_reg;
    logic        out_final_reg;
    logic        out_empty_reg;
    logic        emit;

    assign emit = cmd.emit_pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_coef_reg  <= pend_valid_reg ? pend_reg : 32'd0;
            out_deg_reg   <= pend_valid_reg ? 6'(pend_k_reg) : 6'd0;
            out_final_reg <= cmd.emit_final;
            out_empty_reg <= cmd.emit_final && !pend_valid_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_coefficient   = out_coef_reg;
    assign out_degree        = out_deg_reg;
    assign out_final_term    = out_final_reg;
    assign out_empty_product = out_empty_reg;

    assign status.i_last     = i_reg == IW'(DEG - 1);
    assign status.k_zero     = k_reg == '0;
    assign status.acc_nz     = acc_reg != '0;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty_product |-> out_final_term && out_coefficient == 0)
        else $error("empty result is malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_empty_product |-> out_coefficient != 0)
        else $error("zero coefficient given as a term");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || out_ready)
        else $error("output register overwritten");

endmodule

>>> hw/rtl/poly_text_parse_multiply.sv
// Top level of the polynomial text multiplier: joins controller and datapath.
// Depends on ptpm_pkg, ptpm_in_if, ptpm_out_if, ptpm_ctrl and ptpm_datapath.
//
// Usage. The in_chan sink takes one text character a transfer, with kind
// selecting the first or the second polynomial and end_of_text on its last
// character; while parsing, in_chan is always ready. The transfer that ends
// a second text starts the product: the block then walks every product
// degree from 2*DEG-2 down to 0, multiplying and accumulating over the first
// store, then draining and checking the degree, while in_chan is not ready.
// Nonzero terms leave on out_chan from the highest degree down, the last one
// marked final_term; an all-zero product gives one transfer with empty_product
// set. A term is held in an output register and the next in a pending
// register, so a stalled receiver holds the walk only at a third nonzero term
// or the last load. Both stores are cleared as the last term is loaded, and
// parsing resumes. Reset clears the parser, the stores and the output register.
module poly_text_parse_multiply
    import ptpm_pkg::*;
#(
    parameter int DEG = DEG_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    ptpm_in_if.sink    in_chan,
    ptpm_out_if.source out_chan
);

    ptpm_cmd_t    cmd;
    ptpm_status_t status;

    ptpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_kind  (in_chan.kind),
        .in_last  (in_chan.end_of_text),
        .in_ready (in_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptpm_datapath #(
        .DEG (DEG)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_kind           (in_chan.kind),
        .in_text_char      (in_chan.text_char),
        .in_end_of_text    (in_chan.end_of_text),
        .out_valid         (out_chan.valid),
        .out_ready         (out_chan.ready),
        .out_coefficient   (out_chan.coefficient),
        .out_degree        (out_chan.degree),
        .out_final_term    (out_chan.final_term),
        .out_empty_product (out_chan.empty_product)
    );

endmodule
